[src/pidsc_pkg.sv]
// Shared widths, codes and state encoding for the clamped PID step core.
// No dependencies; imported by pid_step_clamped_with_angle_wrap_core.

package pidsc_pkg;

   // stream payload
   localparam int IN_W       = 16;
   localparam int RATE_W     = 8;
   localparam int REQ_DATA_W = 40;   // 2*IN_W + RATE_W, already whole bytes
   localparam int OUT_W      = 16;
   localparam int STAT_W     = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - OUT_W - STAT_W;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_W     = 16;
   localparam int REV_W      = 12;

   // arithmetic widths
   localparam int ERR_W     = 18;            // wrapped error
   localparam int DIFF_W    = ERR_W + 1;     // error minus previous error
   localparam int PROD_W    = ERR_W + GAIN_W; // kp*err and ki*err
   localparam int KDD_W     = DIFF_W + GAIN_W; // kd*diff
   localparam int D_W       = KDD_W + RATE_W; // kd*diff*rate
   localparam int INC_MAG_W = PROD_W - 1;    // |ki*err / rate|
   localparam int INC_W     = PROD_W;
   localparam int INTEG_W   = 48;
   localparam int NI_W      = INTEG_W + 1;
   localparam int PD_W      = D_W + 1;
   localparam int SUM_W     = INTEG_W + 2;
   localparam int MAG_W     = SUM_W - 1;
   localparam int Q_MAG_W   = OUT_W + 1;     // quotient magnitude kept for the clamp
   localparam int Q_W       = Q_MAG_W + 1;
   localparam int DIV_HI_W  = MAG_W - Q_MAG_W;

   // sequencer step counts
   localparam int MUL_STEPS  = GAIN_W;
   localparam int DIV1_STEPS = INC_MAG_W;
   localparam int DIV2_STEPS = Q_MAG_W;
   localparam int STEP_W     = $clog2(DIV1_STEPS + 1);

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAIN_P   = 3'd0,
      CSR_GAIN_I   = 3'd1,
      CSR_GAIN_D   = 3'd2,
      CSR_DIVISOR  = 3'd3,
      CSR_OUT_MAX  = 3'd4,
      CSR_OUT_MIN  = 3'd5,
      CSR_REV_SIZE = 3'd6,
      CSR_WRAP_EN  = 3'd7
   } csr_index_type;

   typedef enum logic [STAT_W-1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_HIGH = 2'd1,
      CLAMP_LOW  = 2'd2
   } clamp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_LOAD,
      ST_MUL,
      ST_PREP1,
      ST_DIV1,
      ST_FIX1,
      ST_ADD1,
      ST_ADD2,
      ST_ABS2,
      ST_PREP2,
      ST_DIV2,
      ST_FIX2,
      ST_CLAMP
   } state_type;

endpackage

[src/pid_step_clamped_with_angle_wrap_core.sv]
// Clamped PID step with optional circular error wrap, bit-serial datapath.
// Depends on pidsc_pkg.

// One request yields one response. The core raises req_tready only in the idle
// state, once the previous result has been loaded into the rsp register, so it
// works on one request at a time. The second divide is skipped when the output
// quotient magnitude does not fit in 17 bits. The work is done by bit-serial
// units: a 16-step shift-add multiply of the three gains, a
// 33-step restoring divide of ki*error by the rate factor (the derivative's rate
// multiply runs alongside it), and a 17-step divide by output_divisor. A finished
// result sits in the rsp register; the core takes the next request while it waits,
// and stalls only when a second result is ready before the first has been taken.
// Registers may be written only while the core is idle. Divisor and rate values
// of zero act as one. The integral absorbs the new increment only on unclamped
// steps and saturates at 48 bits.
module pid_step_clamped_with_angle_wrap_core
   import pidsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // target_value[15:0], measured_value[31:16], rate_factor[39:32]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // control_out[15:0], clamp_status[17:16], zero above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic        [GAIN_W-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in, div_ff, div_in;
   logic signed [OUT_W-1:0]  max_ff, max_in, min_ff, min_in;
   logic        [REV_W-1:0]  rev_ff, rev_in;
   logic                     wrap_ff, wrap_in;

   // control
   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   logic                    step_last;
   logic                    q_sat;

   // loop state
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;

   // item datapath
   logic signed [IN_W-1:0]    tgt_ff, tgt_in, meas_ff, meas_in;
   logic        [RATE_W-1:0]  rate_ff, rate_in, rate_sh_ff, rate_sh_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic        [GAIN_W-1:0]  kp_sh_ff, kp_sh_in, ki_sh_ff, ki_sh_in, kd_sh_ff, kd_sh_in;
   logic signed [PROD_W-1:0]  err_sh_ff, err_sh_in, p_ff, p_in, kie_ff, kie_in;
   logic signed [KDD_W-1:0]   diff_sh_ff, diff_sh_in, kdd_ff, kdd_in;
   logic signed [D_W-1:0]     dmc_ff, dmc_in, d_ff, d_in;
   logic        [INC_MAG_W-1:0] dq1_ff, dq1_in;
   logic        [RATE_W-1:0]  rem1_ff, rem1_in;
   logic                      neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic signed [INC_W-1:0]   inc_ff, inc_in;
   logic signed [NI_W-1:0]    ni_ff, ni_in;
   logic signed [PD_W-1:0]    pd_ff, pd_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic        [MAG_W-1:0]   mag_ff, mag_in;
   logic        [Q_MAG_W-1:0] dq2_ff, dq2_in;
   logic        [GAIN_W-1:0]  rem2_ff, rem2_in;
   logic signed [Q_W-1:0]     q_ff, q_in;

   // output register
   logic signed [OUT_W-1:0]   out_ff, out_in;
   clamp_status_type          stat_ff, stat_in;

   // combinational helpers
   logic        [GAIN_W-1:0]  div_eff;
   logic signed [ERR_W-1:0]   raw_err, half_s, rev_s, low_lim;
   logic signed [DIFF_W-1:0]  diff_val;
   logic signed [PROD_W-1:0]  kie_abs;
   logic signed [SUM_W-1:0]   sum_abs;
   logic        [RATE_W:0]    r1, r1_sub;
   logic        [GAIN_W:0]    r2, r2_sub;
   logic signed [Q_W-1:0]     max_x, min_x;

   assign div_eff   = (div_ff == '0) ? GAIN_W'(1) : div_ff;
   assign step_last = (cnt_ff == '0);
   assign q_sat     = (mag_ff[MAG_W-1:Q_MAG_W] >= DIV_HI_W'(div_eff));

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_ERR;
         ST_ERR:   state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL:   if (step_last) state_in = ST_PREP1;
         ST_PREP1: state_in = ST_DIV1;
         ST_DIV1:  if (step_last) state_in = ST_FIX1;
         ST_FIX1:  state_in = ST_ADD1;
         ST_ADD1:  state_in = ST_ADD2;
         ST_ADD2:  state_in = ST_ABS2;
         ST_ABS2:  state_in = ST_PREP2;
         ST_PREP2: state_in = q_sat ? ST_FIX2 : ST_DIV2;
         ST_DIV2:  if (step_last) state_in = ST_FIX2;
         ST_FIX2:  state_in = ST_CLAMP;
         ST_CLAMP: if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // --- state outputs ---
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_load   = (state_ff == ST_CLAMP) && (!rsp_valid_ff || rsp_tready);
   end

   // --- datapath ---
   always_comb begin
      kp_in = kp_ff;  ki_in = ki_ff;  kd_in = kd_ff;  div_in = div_ff;
      max_in = max_ff; min_in = min_ff; rev_in = rev_ff; wrap_in = wrap_ff;

      cnt_in = cnt_ff;
      integ_in = integ_ff;  prev_in = prev_ff;
      tgt_in = tgt_ff;  meas_in = meas_ff;  rate_in = rate_ff;  rate_sh_in = rate_sh_ff;
      err_in = err_ff;
      kp_sh_in = kp_sh_ff;  ki_sh_in = ki_sh_ff;  kd_sh_in = kd_sh_ff;
      err_sh_in = err_sh_ff;  p_in = p_ff;  kie_in = kie_ff;
      diff_sh_in = diff_sh_ff;  kdd_in = kdd_ff;
      dmc_in = dmc_ff;  d_in = d_ff;
      dq1_in = dq1_ff;  rem1_in = rem1_ff;  neg1_in = neg1_ff;  neg2_in = neg2_ff;
      inc_in = inc_ff;  ni_in = ni_ff;  pd_in = pd_ff;  sum_in = sum_ff;  mag_in = mag_ff;
      dq2_in = dq2_ff;  rem2_in = rem2_ff;  q_in = q_ff;
      out_in = out_ff;  stat_in = stat_ff;

      raw_err  = ERR_W'(tgt_ff) - ERR_W'(meas_ff);
      half_s   = $signed(ERR_W'(rev_ff >> 1));
      rev_s    = $signed(ERR_W'(rev_ff));
      low_lim  = $signed(ERR_W'(1)) - half_s;
      diff_val = DIFF_W'(err_ff) - DIFF_W'(prev_ff);
      kie_abs  = kie_ff[PROD_W-1] ? -kie_ff : kie_ff;
      sum_abs  = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
      r1       = {rem1_ff, dq1_ff[INC_MAG_W-1]};
      r1_sub   = r1 - {1'b0, rate_ff};
      r2       = {rem2_ff, dq2_ff[Q_MAG_W-1]};
      r2_sub   = r2 - {1'b0, div_eff};
      max_x    = Q_W'(max_ff);
      min_x    = Q_W'(min_ff);

      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;

      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_GAIN_P:   kp_in   = csr_wdata;
            CSR_GAIN_I:   ki_in   = csr_wdata;
            CSR_GAIN_D:   kd_in   = csr_wdata;
            CSR_DIVISOR:  div_in  = csr_wdata;
            CSR_OUT_MAX:  max_in  = $signed(csr_wdata);
            CSR_OUT_MIN:  min_in  = $signed(csr_wdata);
            CSR_REV_SIZE: rev_in  = csr_wdata[REV_W-1:0];
            CSR_WRAP_EN:  wrap_in = csr_wdata[0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               tgt_in  = $signed(req_tdata[IN_W-1:0]);
               meas_in = $signed(req_tdata[2*IN_W-1:IN_W]);
               rate_in = (req_tdata[REQ_DATA_W-1:2*IN_W] == '0) ? RATE_W'(1)
                                                                : req_tdata[REQ_DATA_W-1:2*IN_W];
            end
         end
         ST_ERR: begin
            // single wrap correction
            if (wrap_ff && (raw_err > half_s))
               err_in = raw_err - rev_s;
            else if (wrap_ff && (raw_err < low_lim))
               err_in = raw_err + rev_s;
            else
               err_in = raw_err;
         end
         ST_LOAD: begin
            prev_in    = err_ff;
            err_sh_in  = PROD_W'(err_ff);
            diff_sh_in = KDD_W'(diff_val);
            kp_sh_in   = kp_ff;
            ki_sh_in   = ki_ff;
            kd_sh_in   = kd_ff;
            p_in       = '0;
            kie_in     = '0;
            kdd_in     = '0;
            cnt_in     = STEP_W'(MUL_STEPS - 1);
         end
         ST_MUL: begin
            // one gain bit per cycle, LSB first
            if (kp_sh_ff[0]) p_in   = p_ff + err_sh_ff;
            if (ki_sh_ff[0]) kie_in = kie_ff + err_sh_ff;
            if (kd_sh_ff[0]) kdd_in = kdd_ff + diff_sh_ff;
            kp_sh_in   = kp_sh_ff >> 1;
            ki_sh_in   = ki_sh_ff >> 1;
            kd_sh_in   = kd_sh_ff >> 1;
            err_sh_in  = err_sh_ff <<< 1;
            diff_sh_in = diff_sh_ff <<< 1;
            cnt_in     = cnt_ff - STEP_W'(1);
         end
         ST_PREP1: begin
            neg1_in    = kie_ff[PROD_W-1];
            dq1_in     = kie_abs[INC_MAG_W-1:0];
            rem1_in    = '0;
            rate_sh_in = rate_ff;
            dmc_in     = D_W'(kdd_ff);
            d_in       = '0;
            cnt_in     = STEP_W'(DIV1_STEPS - 1);
         end
         ST_DIV1: begin
            // restoring divide of |ki*err| by rate; derivative rate multiply alongside
            if (!r1_sub[RATE_W]) begin
               rem1_in = r1_sub[RATE_W-1:0];
               dq1_in  = {dq1_ff[INC_MAG_W-2:0], 1'b1};
            end else begin
               rem1_in = r1[RATE_W-1:0];
               dq1_in  = {dq1_ff[INC_MAG_W-2:0], 1'b0};
            end
            if (rate_sh_ff[0]) d_in = d_ff + dmc_ff;
            rate_sh_in = rate_sh_ff >> 1;
            dmc_in     = dmc_ff <<< 1;
            cnt_in     = cnt_ff - STEP_W'(1);
         end
         ST_FIX1: begin
            inc_in = neg1_ff ? -$signed({1'b0, dq1_ff}) : $signed({1'b0, dq1_ff});
         end
         ST_ADD1: begin
            ni_in = NI_W'(integ_ff) + NI_W'(inc_ff);
            pd_in = PD_W'(p_ff) + PD_W'(d_ff);
         end
         ST_ADD2: begin
            sum_in = SUM_W'(ni_ff) + SUM_W'(pd_ff);
         end
         ST_ABS2: begin
            neg2_in = sum_ff[SUM_W-1];
            mag_in  = sum_abs[MAG_W-1:0];
         end
         ST_PREP2: begin
            // quotient beyond 17 bits clamps either way; saturate and skip the divide
            if (q_sat) begin
               dq2_in = '1;
            end else begin
               rem2_in = mag_ff[Q_MAG_W+GAIN_W-1:Q_MAG_W];
               dq2_in  = mag_ff[Q_MAG_W-1:0];
               cnt_in  = STEP_W'(DIV2_STEPS - 1);
            end
         end
         ST_DIV2: begin
            if (!r2_sub[GAIN_W]) begin
               rem2_in = r2_sub[GAIN_W-1:0];
               dq2_in  = {dq2_ff[Q_MAG_W-2:0], 1'b1};
            end else begin
               rem2_in = r2[GAIN_W-1:0];
               dq2_in  = {dq2_ff[Q_MAG_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - STEP_W'(1);
         end
         ST_FIX2: begin
            q_in = neg2_ff ? -$signed({1'b0, dq2_ff}) : $signed({1'b0, dq2_ff});
         end
         ST_CLAMP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               // high limit tested first, also with inverted limits
               if (q_ff > max_x) begin
                  out_in  = max_ff;
                  stat_in = CLAMP_HIGH;
               end else if (q_ff < min_x) begin
                  out_in  = min_ff;
                  stat_in = CLAMP_LOW;
               end else begin
                  out_in  = q_ff[OUT_W-1:0];
                  stat_in = CLAMP_NONE;
                  if (ni_ff[NI_W-1] != ni_ff[INTEG_W-1])
                     integ_in = ni_ff[NI_W-1] ? INTEG_MIN : INTEG_MAX;
                  else
                     integ_in = ni_ff[INTEG_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         kp_ff        <= GAIN_W'(1);
         ki_ff        <= '0;
         kd_ff        <= '0;
         div_ff       <= GAIN_W'(1);
         max_ff       <= OUT_W'(98);
         min_ff       <= OUT_W'(2);
         rev_ff       <= REV_W'(360);
         wrap_ff      <= 1'b0;
         integ_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         div_ff       <= div_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         rev_ff       <= rev_in;
         wrap_ff      <= wrap_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff     <= tgt_in;
      meas_ff    <= meas_in;
      rate_ff    <= rate_in;
      rate_sh_ff <= rate_sh_in;
      err_ff     <= err_in;
      kp_sh_ff   <= kp_sh_in;
      ki_sh_ff   <= ki_sh_in;
      kd_sh_ff   <= kd_sh_in;
      err_sh_ff  <= err_sh_in;
      p_ff       <= p_in;
      kie_ff     <= kie_in;
      diff_sh_ff <= diff_sh_in;
      kdd_ff     <= kdd_in;
      dmc_ff     <= dmc_in;
      d_ff       <= d_in;
      dq1_ff     <= dq1_in;
      rem1_ff    <= rem1_in;
      neg1_ff    <= neg1_in;
      neg2_ff    <= neg2_in;
      inc_ff     <= inc_in;
      ni_ff      <= ni_in;
      pd_ff      <= pd_in;
      sum_ff     <= sum_in;
      mag_ff     <= mag_in;
      dq2_ff     <= dq2_in;
      rem2_ff    <= rem2_in;
      q_ff       <= q_in;
      out_ff     <= out_in;
      stat_ff    <= stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, stat_ff, out_ff};

endmodule

[tb/sv/pid_step_clamped_with_angle_wrap_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the clamped PID step core with optional angle wrap.
// Holds its own predictor of the control law; depends on pidsc_pkg and the core RTL.

module pid_step_clamped_with_angle_wrap_core_tb;
   import pidsc_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] control_out;
      clamp_status_type clamp_status;
   } drive_result_type;

   localparam int RANDOM_PHASES    = 11;
   localparam int ITEMS_PER_PHASE  = 175;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor copy of registers and loop state
   longint kp_gain, ki_gain, kd_gain, out_div, out_max, out_min, rev_units;
   bit     wrap_on;
   longint integ_acc;
   longint last_err;

   drive_result_type expected_drive_q[$];
   int               fail_count = 0;
   bit               idle_on    = 1'b1;
   int               stall_left = 0;

   pid_step_clamped_with_angle_wrap_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      #12_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic void reset_predictor();
      kp_gain   = 1;
      ki_gain   = 0;
      kd_gain   = 0;
      out_div   = 1;
      out_max   = 98;
      out_min   = 2;
      rev_units = 360;
      wrap_on   = 1'b0;
      integ_acc = 0;
      last_err  = 0;
   endfunction

   // One control step: wrap, PID terms, divide, clamp, conditional integration.
   function automatic drive_result_type pid_law_predict(input logic [IN_W-1:0] tgt,
                                                        input logic [IN_W-1:0] meas,
                                                        input logic [RATE_W-1:0] rate_in);
      drive_result_type res;
      longint rate, dv, err, half, p_term, inc, d_term, total, q, ni;
      rate = (rate_in == 0) ? 1 : longint'(rate_in);
      dv   = (out_div == 0) ? 1 : out_div;
      err  = longint'($signed(tgt)) - longint'($signed(meas));
      if (wrap_on) begin
         half = rev_units / 2;
         if (err > half)
            err = err - rev_units;
         else if (err < -(half - 1))
            err = err + rev_units;
      end
      p_term = kp_gain * err;
      inc    = (ki_gain * err) / rate;
      d_term = kd_gain * (err - last_err) * rate;
      total  = p_term + integ_acc + inc + d_term;
      q      = total / dv;
      last_err = err;
      // high test first, so inverted limits resolve to output_max
      if (q > out_max) begin
         res.control_out  = out_max[OUT_W-1:0];
         res.clamp_status = CLAMP_HIGH;
      end else if (q < out_min) begin
         res.control_out  = out_min[OUT_W-1:0];
         res.clamp_status = CLAMP_LOW;
      end else begin
         ni = integ_acc + inc;
         if (ni > longint'(INTEG_MAX)) ni = longint'(INTEG_MAX);
         if (ni < longint'(INTEG_MIN)) ni = longint'(INTEG_MIN);
         integ_acc = ni;
         res.control_out  = q[OUT_W-1:0];
         res.clamp_status = CLAMP_NONE;
      end
      return res;
   endfunction

   // result side: random stall bursts while idle_on is set
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drive_q.size() == 0) begin
            $error("unexpected response transfer: rsp_tdata=%h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_drive_q.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want.control_out) begin
               $error("control_out mismatch: expected %0d, actual %0d",
                      $signed(want.control_out), $signed(rsp_tdata[OUT_W-1:0]));
               fail_count++;
            end
            if (rsp_tdata[OUT_W +: STAT_W] !== want.clamp_status) begin
               $error("clamp_status mismatch: expected %0d, actual %0d",
                      want.clamp_status, rsp_tdata[OUT_W +: STAT_W]);
               fail_count++;
            end
         end
      end
   end

   // Called on a falling edge; returns on a falling edge with tvalid possibly held.
   task automatic send_sample(input logic [IN_W-1:0] tgt, input logic [IN_W-1:0] meas,
                              input logic [RATE_W-1:0] rate);
      req_tdata  <= {rate, meas, tgt};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_drive_q.push_back(pid_law_predict(tgt, meas, rate));
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // hold off the sender until every outstanding transfer has been answered
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_drive_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_GAIN_P:   kp_gain   = longint'(val);
         CSR_GAIN_I:   ki_gain   = longint'(val);
         CSR_GAIN_D:   kd_gain   = longint'(val);
         CSR_DIVISOR:  out_div   = longint'(val);
         CSR_OUT_MAX:  out_max   = longint'($signed(val));
         CSR_OUT_MIN:  out_min   = longint'($signed(val));
         CSR_REV_SIZE: rev_units = longint'(val[REV_W-1:0]);
         CSR_WRAP_EN:  wrap_on   = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] dv);
      write_csr(CSR_GAIN_P, kp);
      write_csr(CSR_GAIN_I, ki);
      write_csr(CSR_GAIN_D, kd);
      write_csr(CSR_DIVISOR, dv);
   endtask

   task automatic load_limits(input logic [15:0] hi, input logic [15:0] lo);
      write_csr(CSR_OUT_MAX, hi);
      write_csr(CSR_OUT_MIN, lo);
   endtask

   task automatic test_reset_defaults();
      send_sample(16'sd50, 16'sd0, 8'd0);
      send_sample(16'h7FFF, 16'h8000, 8'd1);
      send_sample(16'h8000, 16'h7FFF, 8'd255);
   endtask

   task automatic test_gain_extremes();
      drain_results();
      load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      load_limits(16'h7FFF, 16'h8000);
      send_sample(16'h7FFF, 16'h8000, 8'd255);
      send_sample(16'h8000, 16'h7FFF, 8'd255);
      send_sample(16'h0000, 16'h0000, 8'd0);
      send_sample(16'd100, -16'sd100, 8'd1);
      send_sample(16'hFFFF, 16'h0000, 8'd128);
   endtask

   task automatic test_zero_divisor();
      drain_results();
      load_gains(16'd1, 16'd1, 16'd0, 16'd0);
      send_sample(16'd1000, 16'd0, 8'd0);
      send_sample(-16'sd1000, 16'd0, 8'd3);
      send_sample(16'd7, 16'd0, 8'd2);
   endtask

   task automatic test_inverted_limits();
      drain_results();
      load_gains(16'd1, 16'd0, 16'd0, 16'd1);
      load_limits(-16'sd100, 16'sd100);
      send_sample(16'd0, 16'd0, 8'd1);
      send_sample(-16'sd500, 16'd0, 8'd1);
      send_sample(16'd200, 16'd0, 8'd1);
   endtask

   task automatic test_angle_wrap();
      drain_results();
      load_limits(16'h7FFF, 16'h8000);
      write_csr(CSR_WRAP_EN, 16'd1);
      write_csr(CSR_REV_SIZE, 16'd360);
      // both sides of each wrap threshold
      send_sample(16'd181, 16'd0, 8'd1);
      send_sample(16'd180, 16'd0, 8'd1);
      send_sample(-16'sd179, 16'd0, 8'd1);
      send_sample(-16'sd180, 16'd0, 8'd1);
      drain_results();
      write_csr(CSR_REV_SIZE, 16'd0);
      send_sample(16'd5, 16'd0, 8'd1);
      send_sample(16'd0, 16'd0, 8'd1);
      drain_results();
      write_csr(CSR_REV_SIZE, 16'd1);
      send_sample(16'd3, 16'd0, 8'd1);
      drain_results();
      write_csr(CSR_REV_SIZE, 16'hFFFF);
      send_sample(16'h7FFF, 16'h8000, 8'd1);
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 15));
         3:       return 16'($urandom_range(16, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_divisor();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(2, 4096));
      endcase
   endfunction

   task automatic apply_random_setup(input int phase);
      logic [15:0] hi, lo, rv, wr;
      case (phase)
         0: begin
            load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            hi = 16'h7FFF;
            lo = 16'h8000;
            rv = 16'h0FFF;
            wr = 16'd1;
         end
         1: begin
            load_gains(16'd0, 16'd0, 16'd0, 16'd0);
            hi = 16'h8000;
            lo = 16'h8000;
            rv = 16'd2;
            wr = 16'd0;
         end
         default: begin
            load_gains(pick_gain(), pick_gain(), pick_gain(), pick_divisor());
            if ($urandom_range(0, 3) == 0) begin
               hi = 16'($urandom);
               lo = 16'($urandom);
            end else begin
               hi = 16'($urandom_range(0, 32767));
               lo = 16'(-$urandom_range(0, 32768));
            end
            // upper bits of the narrow registers are don't-care
            rv = {4'($urandom), ($urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 720)))};
            wr = {15'($urandom), 1'($urandom)};
         end
      endcase
      load_limits(hi, lo);
      write_csr(CSR_REV_SIZE, rv);
      write_csr(CSR_WRAP_EN, wr);
   endtask

   task automatic send_random_sample();
      logic [15:0] tgt, meas;
      logic [7:0]  rate;
      int          half;
      tgt  = 16'($urandom);
      meas = 16'($urandom);
      rate = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: meas = tgt + 16'($urandom_range(0, 64)) - 16'd32;
         8: begin
            tgt  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            meas = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         end
         9: begin
            // land near the wrap thresholds
            half = int'(rev_units / 2);
            meas = 16'd0;
            tgt  = 16'(half + $urandom_range(0, 3) - 1);
            if ($urandom_range(0, 1)) tgt = -tgt + 16'd1;
         end
         default: ;
      endcase
      send_sample(tgt, meas, rate);
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_results();
         idle_on = (ph < RANDOM_PHASES - 1);
         apply_random_setup(ph);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2) drain_results();
            send_random_sample();
         end
      end
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_gain_extremes();
      test_zero_divisor();
      test_inverted_limits();
      test_angle_wrap();
      test_random_traffic();

      drain_results();
      repeat (100) @(posedge clock);
      if (expected_drive_q.size() != 0) begin
         $error("%0d responses never arrived", expected_drive_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
src/pidsc_pkg.sv
src/pid_step_clamped_with_angle_wrap_core.sv
tb/sv/pid_step_clamped_with_angle_wrap_core_tb.sv
